// File: sv/sorted_table_membership_count_macros.svh
// assertion macros for the sorted table membership counter
// used by the top level only; no other dependencies
`ifndef SORTED_TABLE_MEMBERSHIP_COUNT_MACROS_SVH
`define SORTED_TABLE_MEMBERSHIP_COUNT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled during reset
`define STMC_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stmc assertion failed");

// next-cycle implication, disabled during reset
`define STMC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stmc assertion failed");

`else

`define STMC_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define STMC_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// File: sv/stmc_pkg.sv
// shared types and constants for the sorted table membership counter
// no dependencies
package stmc_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int LEN_W       = IDX_W + 1;
   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 32;
   localparam int OP_W        = 2;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [OP_W-1:0]    OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0]    OP_QUERY  = 2'd1;
   localparam logic [OP_W-1:0]    OP_CLEAR  = 2'd2;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic               found;
      logic [COUNT_W-1:0] hit_count;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_QUERY,
      CMD_CLEAR
   } cmd_type;

   typedef struct packed {
      cmd_type                   cmd;
      logic signed [VALUE_W-1:0] value;
   } task_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_COMPARE
   } state_type;

endpackage

// File: sv/sorted_table_membership_count.sv
// sorted table membership counter: top level
// ties front end, work queue and search engine; depends on stmc_pkg and the macro header
//
// usage:
//   a request (req_item.op, req_item.value) is taken on a rising edge with start high
//   and busy low. op load appends value to the table (ignored once 1024 entries are
//   held), op query runs a binary search for value, op clear empties the table and
//   zeroes the hit count; the fourth op code is taken and does nothing.
//   only a query gives a response: rsp_strobe is high for one cycle with
//   rsp_item.found and rsp_item.hit_count (found queries since clear, saturating).
//   requests go into a four-entry queue, so busy rises only when that queue is full.
//   a load or clear is handled in the idle state of the search engine. a query passes
//   through idle, then a memory read state and a compare state per probe, at most 11
//   probes for a full table; the response is registered and shows in the cycle
//   after the final compare. the search engine works on one item at a time.
//   the response port has no back pressure; every response must be taken when shown.
//   reset empties the queue and the table and clears the hit count; table contents
//   are not cleared, only the fill count.
`include "sorted_table_membership_count_macros.svh"

module sorted_table_membership_count (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  stmc_pkg::req_type req_item,
   output logic              rsp_strobe,
   output stmc_pkg::rsp_type rsp_item
);
   import stmc_pkg::*;

   queue_status_type q_status;
   logic             push;
   task_type         push_entry;
   logic             pop;
   task_type         pop_entry;

   stmc_front u_front (
      .start      (start),
      .req_item   (req_item),
      .q_status   (q_status),
      .busy       (busy),
      .push       (push),
      .push_entry (push_entry)
   );

   stmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   stmc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop_entry  (pop_entry),
      .pop        (pop),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   `STMC_ASSERT_IMPLY(a_no_push_when_full, clock, reset, push, !q_status.full)
   `STMC_ASSERT_IMPLY(a_no_pop_when_empty, clock, reset, pop, !q_status.empty)
   `STMC_ASSERT_IMPLY(a_hit_counts_nonzero, clock, reset,
      rsp_strobe && rsp_item.found, rsp_item.hit_count != '0)
   `STMC_ASSERT_NEXT(a_push_fills_queue, clock, reset, push && !pop, !q_status.empty)

endmodule

// File: sv/stmc_front.sv
// front end: takes requests, decodes the op code and pushes work into the queue
// depends on stmc_pkg
module stmc_front (
   input  logic                      start,
   input  stmc_pkg::req_type         req_item,
   input  stmc_pkg::queue_status_type q_status,
   output logic                      busy,
   output logic                      push,
   output stmc_pkg::task_type        push_entry
);
   import stmc_pkg::*;

   logic accept;

   assign busy   = q_status.full;
   assign accept = start && !q_status.full;

   always_comb begin
      push             = 1'b0;
      push_entry.cmd   = CMD_LOAD;
      push_entry.value = req_item.value;
      unique case (req_item.op)
         OP_LOAD: begin
            push           = accept;
            push_entry.cmd = CMD_LOAD;
         end
         OP_QUERY: begin
            push           = accept;
            push_entry.cmd = CMD_QUERY;
         end
         OP_CLEAR: begin
            push           = accept;
            push_entry.cmd = CMD_CLEAR;
         end
         // unused op code is taken and dropped
         default: begin
            push = 1'b0;
         end
      endcase
   end

endmodule

// File: sv/stmc_queue.sv
// short fifo of decoded work between the front end and the search engine
// depends on stmc_pkg
module stmc_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  stmc_pkg::task_type         push_entry,
   input  logic                       pop,
   output stmc_pkg::task_type         pop_entry,
   output stmc_pkg::queue_status_type q_status
);
   import stmc_pkg::*;

   task_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QPTR_W:0]     count_ff;
   logic [QPTR_W:0]     count_in;
   logic                do_push;
   logic                do_pop;

   assign q_status.full  = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_entry      = slot_ff[rd_ptr_ff];

   assign do_push = push && !q_status.full;
   assign do_pop  = pop && !q_status.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// File: sv/stmc_back.sv
// back end: table memory, length and hit counters, binary search sequencer
// depends on stmc_pkg
module stmc_back (
   input  logic                       clock,
   input  logic                       reset,
   input  stmc_pkg::queue_status_type q_status,
   input  stmc_pkg::task_type         pop_entry,
   output logic                       pop,
   output logic                       rsp_strobe,
   output stmc_pkg::rsp_type          rsp_item
);
   import stmc_pkg::*;

   logic [VALUE_W-1:0]        table_mem [TABLE_DEPTH];

   state_type                 state_ff;
   state_type                 state_in;
   logic [LEN_W-1:0]          len_ff;
   logic [LEN_W-1:0]          len_in;
   logic [COUNT_W-1:0]        hits_ff;
   logic [COUNT_W-1:0]        hits_in;
   logic [LEN_W-1:0]          left_ff;
   logic [LEN_W-1:0]          left_in;
   logic [LEN_W-1:0]          hi_ff;
   logic [LEN_W-1:0]          hi_in;
   logic [IDX_W-1:0]          mid_ff;
   logic [IDX_W-1:0]          mid_in;
   logic signed [VALUE_W-1:0] key_ff;
   logic signed [VALUE_W-1:0] key_in;
   logic signed [VALUE_W-1:0] rd_data_ff;
   logic                      rsp_strobe_ff;
   logic                      rsp_strobe_in;
   rsp_type                   rsp_item_ff;
   rsp_type                   rsp_item_in;

   logic                      wr_en;
   logic                      rd_en;
   logic [IDX_W-1:0]          rd_addr;
   logic [LEN_W:0]            mid_sum;
   logic [IDX_W-1:0]          mid_calc;
   logic [LEN_W-1:0]          left_next;
   logic [LEN_W-1:0]          hi_next;
   logic [COUNT_W-1:0]        hits_inc;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // hi is exclusive, so the probe is (left + hi - 1) / 2
   assign mid_sum  = {1'b0, left_ff} + {1'b0, hi_ff} - 1'b1;
   assign mid_calc = mid_sum[IDX_W:1];
   assign hits_inc = (hits_ff != COUNT_MAX) ? hits_ff + 1'b1 : hits_ff;

   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      hits_in       = hits_ff;
      left_in       = left_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      key_in        = key_ff;
      rsp_strobe_in = 1'b0;
      rsp_item_in   = rsp_item_ff;
      pop           = 1'b0;
      wr_en         = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = mid_calc;
      left_next     = left_ff;
      hi_next       = hi_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               pop = 1'b1;
               unique case (pop_entry.cmd)
                  CMD_LOAD: begin
                     if (len_ff < LEN_W'(TABLE_DEPTH)) begin
                        wr_en  = 1'b1;
                        len_in = len_ff + 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     len_in  = '0;
                     hits_in = '0;
                  end
                  CMD_QUERY: begin
                     key_in  = pop_entry.value;
                     left_in = '0;
                     hi_in   = len_ff;
                     if (len_ff == '0) begin
                        rsp_strobe_in         = 1'b1;
                        rsp_item_in.found     = 1'b0;
                        rsp_item_in.hit_count = hits_ff;
                     end else begin
                        state_in = ST_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rd_en    = 1'b1;
            mid_in   = mid_calc;
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (rd_data_ff == key_ff) begin
               rsp_strobe_in         = 1'b1;
               rsp_item_in.found     = 1'b1;
               rsp_item_in.hit_count = hits_inc;
               hits_in               = hits_inc;
               state_in              = ST_IDLE;
            end else begin
               if (rd_data_ff < key_ff) begin
                  left_next = {1'b0, mid_ff} + 1'b1;
               end else begin
                  hi_next = {1'b0, mid_ff};
               end
               left_in = left_next;
               hi_in   = hi_next;
               if (left_next < hi_next) begin
                  state_in = ST_READ;
               end else begin
                  rsp_strobe_in         = 1'b1;
                  rsp_item_in.found     = 1'b0;
                  rsp_item_in.hit_count = hits_ff;
                  state_in              = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         len_ff        <= '0;
         hits_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         len_ff        <= len_in;
         hits_ff       <= hits_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      hi_ff       <= hi_in;
      mid_ff      <= mid_in;
      key_ff      <= key_in;
      rsp_item_ff <= rsp_item_in;
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[len_ff[IDX_W-1:0]] <= pop_entry.value;
      end
      if (rd_en) begin
         rd_data_ff <= table_mem[rd_addr];
      end
   end

endmodule

// File: tb/tb.sv
// testbench for the sorted table membership counter: directed and random requests
// with a binary search predictor checking every query response; uses stmc_pkg
`timescale 1ns / 1ps

module tb;
   import stmc_pkg::*;

   localparam logic [OP_W-1:0] OP_NOP = 2'd3;   // unused op code, taken and ignored
   localparam int TIMEOUT_NS = 5_000_000;
   localparam int DRAIN_CYCLES = 40;
   localparam int RANDOM_ITEMS = 410;

   logic    clock;
   logic    reset;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_strobe;
   rsp_type rsp_item;

   sorted_table_membership_count DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // shadow copy of the block state
   logic signed [VALUE_W-1:0] shadow_table [TABLE_DEPTH];
   int unsigned               shadow_len;
   logic [COUNT_W-1:0]        shadow_hits;

   req_type     pending_requests [$];
   rsp_type     expected_answers [$];
   int          key_pool [$];
   int unsigned requests_issued;
   int unsigned requests_taken;
   int unsigned error_count;
   int          burst_left;
   int          gap_left;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   function automatic bit probe_search(logic signed [VALUE_W-1:0] key);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = int'(shadow_len) - 1;
      while (lo <= hi) begin
         mid = (lo + hi) / 2;
         if (shadow_table[mid] == key) return 1'b1;
         if (shadow_table[mid] < key) lo = mid + 1;
         else hi = mid - 1;
      end
      return 1'b0;
   endfunction

   task automatic apply_request(req_type r);
      rsp_type answer;
      case (r.op)
         OP_LOAD: begin
            if (shadow_len < TABLE_DEPTH) begin
               shadow_table[shadow_len] = r.value;
               shadow_len++;
            end
         end
         OP_QUERY: begin
            answer.found = probe_search(r.value);
            if (answer.found && shadow_hits != COUNT_MAX) shadow_hits++;
            answer.hit_count = shadow_hits;
            expected_answers.push_back(answer);
         end
         OP_CLEAR: begin
            shadow_len = 0;
            shadow_hits = '0;
         end
         default: begin
         end
      endcase
   endtask

   function automatic int random_word();
      case ($urandom_range(0, 15))
         0: return 32'sh8000_0000;
         1: return 32'sh7fff_ffff;
         2: return 0;
         3: return -1;
         default: return int'($urandom());
      endcase
   endfunction

   function automatic int pick_key();
      int k;
      if (key_pool.size() == 0) return random_word();
      k = key_pool[$urandom_range(0, key_pool.size() - 1)];
      case ($urandom_range(0, 19))
         0, 1, 2: return k + 1;
         3, 4, 5: return k - 1;
         6, 7, 8, 9, 10: return random_word();
         default: return k;
      endcase
   endfunction

   task automatic queue_request(logic [OP_W-1:0] op, int value);
      req_type r;
      r.op = op;
      r.value = value;
      pending_requests.push_back(r);
      if (op == OP_CLEAR) key_pool.delete();
   endtask

   task automatic queue_load_run(int n, bit ascending);
      int vals [$];
      for (int i = 0; i < n; i++) vals.push_back(random_word());
      if (ascending) vals.sort();
      foreach (vals[i]) begin
         queue_request(OP_LOAD, vals[i]);
         key_pool.push_back(vals[i]);
      end
   endtask

   // driver: bursts of requests with random gaps
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && requests_taken != requests_issued) begin
         // request still waiting for busy to drop
      end else if (gap_left > 0) begin
         gap_left--;
         start <= 1'b0;
      end else if (pending_requests.size() > 0) begin
         req_item <= pending_requests.pop_front();
         start <= 1'b1;
         requests_issued++;
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                       : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         end
      end else begin
         start <= 1'b0;
      end
   end

   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         requests_taken++;
         apply_request(req_item);
      end
   end

   // monitor
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: response with nothing expected: found %0b hit_count %0d",
                     $time, rsp_item.found, rsp_item.hit_count);
            error_count++;
         end else begin
            want = expected_answers.pop_front();
            if (rsp_item.found !== want.found) begin
               $display("%0t: found mismatch: expected %0b actual %0b",
                        $time, want.found, rsp_item.found);
               error_count++;
            end
            if (rsp_item.hit_count !== want.hit_count) begin
               $display("%0t: hit_count mismatch: expected %0d actual %0d",
                        $time, want.hit_count, rsp_item.hit_count);
               error_count++;
            end
         end
      end
   end

   initial begin
      int random_items;
      int n;
      shadow_len = 0;
      shadow_hits = '0;
      requests_issued = 0;
      requests_taken = 0;
      error_count = 0;
      burst_left = 1;
      gap_left = 0;
      reset = 1'b1;

      // directed: empty table, extreme values, hits and misses, unused op, clear
      queue_request(OP_QUERY, 0);
      queue_request(OP_LOAD, 32'sh8000_0000);
      queue_request(OP_LOAD, -1);
      queue_request(OP_LOAD, 0);
      queue_request(OP_LOAD, 1);
      queue_request(OP_LOAD, 32'sh7fff_ffff);
      queue_request(OP_QUERY, 32'sh8000_0000);
      queue_request(OP_QUERY, -1);
      queue_request(OP_QUERY, 0);
      queue_request(OP_QUERY, 1);
      queue_request(OP_QUERY, 32'sh7fff_ffff);
      queue_request(OP_QUERY, 32'sh8000_0001);
      queue_request(OP_QUERY, -2);
      queue_request(OP_QUERY, 2);
      queue_request(OP_QUERY, 32'sh7fff_fffe);
      queue_request(OP_NOP, 32'sh7fff_ffff);
      queue_request(OP_QUERY, 1);
      queue_request(OP_CLEAR, -1);
      queue_request(OP_QUERY, 0);
      queue_request(OP_LOAD, 5);
      queue_request(OP_QUERY, 5);
      queue_request(OP_QUERY, 4);

      // random phases: mostly sorted loads followed by queries, with some noise
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) != 0) begin
            queue_request(OP_CLEAR, int'($urandom()));
            random_items++;
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 24);
         queue_load_run(n, $urandom_range(0, 7) != 0);
         random_items += n;
         n = $urandom_range(2, 20);
         for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 19))
               0: queue_request(OP_NOP, int'($urandom()));
               1: begin
                  queue_load_run(1, 1'b0);
                  random_items++;
               end
               default: begin
                  queue_request(OP_QUERY, pick_key());
                  random_items++;
               end
            endcase
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || requests_taken != requests_issued)
         @(posedge clock);
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
